// ===== hdl/deq_pkg.sv =====
// Shared types, codes and field widths for the double-ended queue.
package deq_pkg;

    localparam int FUNC_W        = 3;
    localparam int VALUE_W       = 64;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_COUNT_W = 5;

    localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_LIST_FWD   = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_LIST_REV   = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD_AT_COUNT,
        CELL_SHIFT_FROM_LEFT,
        CELL_SHIFT_FROM_RIGHT,
        CELL_ROTATE_FWD
    } t_cell_op;

    typedef struct packed {
        t_cell_op                   op;
        logic signed [VALUE_W-1:0]  bcast;
    } t_cell_ctl;

    typedef enum logic {
        ST_IDLE,
        ST_LIST
    } t_ctrl_state;

endpackage

// ===== hdl/deq_in_if.sv =====
// Input channel of the double-ended queue: operation code and push value.
interface deq_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [deq_pkg::FUNC_W-1:0]             func;
    logic signed [deq_pkg::VALUE_W-1:0]     push_value;

    modport source (output valid, output func, output push_value, input ready);
    modport sink   (input valid, input func, input push_value, output ready);
endinterface

// ===== hdl/deq_out_if.sv =====
// Output channel of the double-ended queue: one result item per handshake.
interface deq_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [deq_pkg::VALUE_W-1:0]     out_value;
    logic                                   has_value;
    logic [deq_pkg::STATUS_W-1:0]           status;
    logic                                   now_empty;
    logic [deq_pkg::ENTRY_COUNT_W-1:0]      entry_count;
    logic                                   last;

    modport source (output valid, output out_value, output has_value, output status,
                    output now_empty, output entry_count, output last, input ready);
    modport sink   (input valid, input out_value, input has_value, input status,
                    input now_empty, input entry_count, input last, output ready);
endinterface

// ===== hdl/deq_cell.sv =====
// One storage cell of the queue chain; position INDEX counted from the front.
module deq_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  logic                                i_clk,
    input  deq_pkg::t_cell_ctl                  i_ctl,
    input  logic [CNT_W-1:0]                    i_count,
    input  logic signed [deq_pkg::VALUE_W-1:0]  i_left,
    input  logic signed [deq_pkg::VALUE_W-1:0]  i_right,
    output logic signed [deq_pkg::VALUE_W-1:0]  o_data,
    output logic signed [deq_pkg::VALUE_W-1:0]  o_tail_data
);

    logic signed [deq_pkg::VALUE_W-1:0] r_data;
    logic signed [deq_pkg::VALUE_W-1:0] n_data;
    logic                               w_at_count;
    logic                               w_is_tail;

    assign w_at_count = (i_count == CNT_W'(INDEX));
    assign w_is_tail  = (i_count == CNT_W'(INDEX + 1));

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            deq_pkg::CELL_HOLD:             n_data = r_data;
            deq_pkg::CELL_LOAD_AT_COUNT:    if (w_at_count) n_data = i_ctl.bcast;
            deq_pkg::CELL_SHIFT_FROM_LEFT:  n_data = i_left;
            deq_pkg::CELL_SHIFT_FROM_RIGHT: n_data = i_right;
            deq_pkg::CELL_ROTATE_FWD:       n_data = w_is_tail ? i_ctl.bcast : i_right;
            default:                        n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data      = r_data;
    assign o_tail_data = w_is_tail ? r_data : '0;

endmodule

// ===== hdl/double_ended_queue.sv =====
// Top level of the double-ended queue: a chain of storage cells and its controller.
//
//   channel  | dir | handshake        | payload
//   ---------+-----+------------------+----------------------------------------------
//   i_in     | in  | valid / ready    | func, push_value
//   o_out    | out | valid / ready    | out_value, has_value, status, now_empty,
//            |     |                  | entry_count, last
//
// Flow: a push or a pop gives one result item; a new item can follow in the next
// cycle as long as the output register is free or being drained. A listing holds
// input off until all N entries are sent: the chain rotates by one cell per cycle,
// presenting the front (forward) or tail (reverse) cell, and ends restored.
// Reset clears the entry count, controller state and output valid; cell contents are
// left as they are, since no slot is read before it is written.
// Stalls: a stalled result holds in the output register; listing advances only on
// cycles where that register can take a new result.
module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    deq_in_if.sink      i_in,
    deq_out_if.source   o_out
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // Cell chain wiring
    deq_pkg::t_cell_ctl                 w_ctl;
    logic signed [deq_pkg::VALUE_W-1:0] w_data [DEPTH];
    logic signed [deq_pkg::VALUE_W-1:0] w_tail_part [DEPTH];
    logic signed [deq_pkg::VALUE_W-1:0] w_tail;
    logic signed [deq_pkg::VALUE_W-1:0] w_front;

    // Control registers
    deq_pkg::t_ctrl_state r_state;
    deq_pkg::t_ctrl_state n_state;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [CNT_W-1:0]     r_left;
    logic [CNT_W-1:0]     n_left;
    logic                 r_rev;
    logic                 n_rev;

    // Output register
    logic                                r_out_valid;
    logic signed [deq_pkg::VALUE_W-1:0]  r_out_value;
    logic                                r_out_has;
    logic [deq_pkg::STATUS_W-1:0]        r_out_status;
    logic [CNT_W-1:0]                    r_out_count;
    logic                                r_out_last;

    logic                                w_load_out;
    logic signed [deq_pkg::VALUE_W-1:0]  w_res_value;
    logic                                w_res_has;
    logic [deq_pkg::STATUS_W-1:0]        w_res_status;
    logic                                w_res_last;

    logic w_out_free;
    logic w_accept;
    logic w_empty;
    logic w_full;
    logic w_is_list;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == deq_pkg::ST_IDLE) && w_out_free;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_empty    = (r_count == '0);
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_is_list  = (i_in.func == deq_pkg::FUNC_LIST_FWD) ||
                        (i_in.func == deq_pkg::FUNC_LIST_REV);

    // Chain of cells: each cell sees its neighbors; the ends take the broadcast value
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [deq_pkg::VALUE_W-1:0] w_left_in;
        logic signed [deq_pkg::VALUE_W-1:0] w_right_in;

        if (g == 0) begin : g_first
            assign w_left_in = w_ctl.bcast;
        end else begin : g_inner_l
            assign w_left_in = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right_in = w_ctl.bcast;
        end else begin : g_inner_r
            assign w_right_in = w_data[g+1];
        end

        deq_cell #(
            .INDEX (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_count     (r_count),
            .i_left      (w_left_in),
            .i_right     (w_right_in),
            .o_data      (w_data[g]),
            .o_tail_data (w_tail_part[g])
        );
    end

    // Only the tail cell drives a nonzero masked value; OR them together
    always_comb begin
        w_tail = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_tail = w_tail | w_tail_part[k];
        end
    end

    assign w_front = w_data[0];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            deq_pkg::ST_IDLE: begin
                if (w_accept && w_is_list && !w_empty) n_state = deq_pkg::ST_LIST;
            end
            deq_pkg::ST_LIST: begin
                if (w_out_free && (r_left == CNT_W'(1))) n_state = deq_pkg::ST_IDLE;
            end
            default: n_state = deq_pkg::ST_IDLE;
        endcase
    end

    // Datapath control and result formation
    always_comb begin
        w_ctl.op     = deq_pkg::CELL_HOLD;
        w_ctl.bcast  = '0;
        n_count      = r_count;
        n_left       = r_left;
        n_rev        = r_rev;
        w_load_out   = 1'b0;
        w_res_value  = '0;
        w_res_has    = 1'b0;
        w_res_status = deq_pkg::STATUS_OK;
        w_res_last   = 1'b1;

        case (r_state)
            deq_pkg::ST_IDLE: begin
                if (w_accept) begin
                    w_load_out = 1'b1;
                    case (i_in.func)
                        deq_pkg::FUNC_PUSH_BACK: begin
                            if (w_full) begin
                                w_res_status = deq_pkg::STATUS_FULL;
                            end else begin
                                w_ctl.op    = deq_pkg::CELL_LOAD_AT_COUNT;
                                w_ctl.bcast = i_in.push_value;
                                n_count     = r_count + CNT_W'(1);
                            end
                        end
                        deq_pkg::FUNC_PUSH_FRONT: begin
                            if (w_full) begin
                                w_res_status = deq_pkg::STATUS_FULL;
                            end else begin
                                w_ctl.op    = deq_pkg::CELL_SHIFT_FROM_LEFT;
                                w_ctl.bcast = i_in.push_value;
                                n_count     = r_count + CNT_W'(1);
                            end
                        end
                        deq_pkg::FUNC_POP_BACK: begin
                            if (w_empty) begin
                                w_res_status = deq_pkg::STATUS_EMPTY;
                            end else begin
                                // Tail cell is simply abandoned
                                w_res_value = w_tail;
                                w_res_has   = 1'b1;
                                n_count     = r_count - CNT_W'(1);
                            end
                        end
                        deq_pkg::FUNC_POP_FRONT: begin
                            if (w_empty) begin
                                w_res_status = deq_pkg::STATUS_EMPTY;
                            end else begin
                                w_res_value = w_front;
                                w_res_has   = 1'b1;
                                w_ctl.op    = deq_pkg::CELL_SHIFT_FROM_RIGHT;
                                n_count     = r_count - CNT_W'(1);
                            end
                        end
                        deq_pkg::FUNC_LIST_FWD,
                        deq_pkg::FUNC_LIST_REV: begin
                            if (w_empty) begin
                                w_res_status = deq_pkg::STATUS_EMPTY;
                            end else begin
                                // Results come from the listing walk instead
                                w_load_out = 1'b0;
                                n_left     = r_count;
                                n_rev      = (i_in.func == deq_pkg::FUNC_LIST_REV);
                            end
                        end
                        default: begin
                            w_res_status = deq_pkg::STATUS_OK;
                        end
                    endcase
                end
            end
            deq_pkg::ST_LIST: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    w_res_has  = 1'b1;
                    w_res_last = (r_left == CNT_W'(1));
                    n_left     = r_left - CNT_W'(1);
                    if (r_rev) begin
                        // Emit the tail, rotate it round to the front
                        w_res_value = w_tail;
                        w_ctl.op    = deq_pkg::CELL_SHIFT_FROM_LEFT;
                        w_ctl.bcast = w_tail;
                    end else begin
                        // Emit the front, rotate it round to the tail
                        w_res_value = w_front;
                        w_ctl.op    = deq_pkg::CELL_ROTATE_FWD;
                        w_ctl.bcast = w_front;
                    end
                end
            end
            default: begin
                w_ctl.op = deq_pkg::CELL_HOLD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= deq_pkg::ST_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_rev       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
            r_rev   <= n_rev;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload: load with each new result, hold while stalled
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_value  <= w_res_value;
            r_out_has    <= w_res_has;
            r_out_status <= w_res_status;
            r_out_count  <= n_count;
            r_out_last   <= w_res_last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_value   = r_out_value;
    assign o_out.has_value   = r_out_has;
    assign o_out.status      = r_out_status;
    assign o_out.now_empty   = (r_out_count == '0);
    assign o_out.entry_count = deq_pkg::ENTRY_COUNT_W'(r_out_count);
    assign o_out.last        = r_out_last;

endmodule
